[sv/ess_pkg.sv]
// Shared types and constants of the escaped string scanner.
`default_nettype none
package ess_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned KindW  = 2;

  // Result kinds
  localparam logic [KindW-1:0] KindData  = 2'd0;
  localparam logic [KindW-1:0] KindOk    = 2'd1;
  localparam logic [KindW-1:0] KindError = 2'd2;

  // Characters the scanner recognizes
  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChBs    = 8'h08;
  localparam logic [ByteW-1:0] ChFf    = 8'h0c;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChSeven = 8'h37;
  localparam logic [ByteW-1:0] ChB     = 8'h62;
  localparam logic [ByteW-1:0] ChF     = 8'h66;
  localparam logic [ByteW-1:0] ChN     = 8'h6e;
  localparam logic [ByteW-1:0] ChR     = 8'h72;
  localparam logic [ByteW-1:0] ChS     = 8'h73;
  localparam logic [ByteW-1:0] ChT     = 8'h74;

  localparam logic [ByteW-1:0]  EscReset = 8'h5c;
  localparam logic [CountW-1:0] CountMax = 16'hffff;

  typedef struct packed {
    logic [CountW-1:0] copied_total;
    logic [ByteW-1:0]  out_byte;
    logic [KindW-1:0]  kind;
    logic              last;
  } res_t;

  // Up to two results produced by one accepted byte
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage
`default_nettype wire

[sv/ess_core.sv]
// Scanner state and the per-byte decode that turns one byte into zero to two results.
`default_nettype none
module ess_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               accept_i,
  input  wire logic [7:0]         text_byte_i,
  input  wire logic               starts_string_i,
  input  wire logic               quoted_i,
  output      ess_pkg::push_t     push_o
);
  import ess_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhBody = 2'd1;
  localparam logic [1:0] PhEsc  = 2'd2;
  localparam logic [1:0] PhOct  = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic              qmode_q, qmode_d;
  logic [ByteW-1:0]  qbyte_q, qbyte_d;
  logic [ByteW-1:0]  acc_q, acc_d;
  logic [1:0]        digs_q, digs_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]  esc_q;
  push_t             push;
  logic              do_body;

  function automatic push_t append(push_t p, logic [ByteW-1:0] b, logic [KindW-1:0] k,
                                   logic [CountW-1:0] c);
    res_t r;
    r.copied_total = c;
    r.out_byte     = b;
    r.kind         = k;
    r.last         = 1'b0;
    if (p.num == 2'd0) begin
      p.r0 = r;
    end else begin
      p.r1 = r;
    end
    p.num = p.num + 2'd1;
    return p;
  endfunction

  function automatic logic [CountW-1:0] bump(logic [CountW-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  always_comb begin
    phase_d = phase_q;
    qmode_d = qmode_q;
    qbyte_d = qbyte_q;
    acc_d   = acc_q;
    digs_d  = digs_q;
    cnt_d   = cnt_q;
    do_body = 1'b0;
    push    = '0;

    if (starts_string_i) begin
      // Abandon any open string and start over
      cnt_d   = '0;
      acc_d   = '0;
      digs_d  = '0;
      qbyte_d = '0;
      qmode_d = quoted_i;
      if (quoted_i) begin
        if (text_byte_i == ChNul) begin
          phase_d = PhIdle;
          push    = append(push, ChNul, KindError, cnt_d);
        end else begin
          qbyte_d = text_byte_i;
          phase_d = PhBody;
        end
      end else begin
        phase_d = PhBody;
        do_body = 1'b1;
      end
    end else begin
      case (phase_q)
        PhBody: do_body = 1'b1;
        PhEsc: begin
          phase_d = PhBody;
          case (text_byte_i)
            ChNul: begin
              phase_d = PhIdle;
              push    = append(push, ChNul, KindError, cnt_d);
            end
            ChZero: begin
              phase_d = PhOct;
              acc_d   = '0;
              digs_d  = '0;
            end
            default: begin
              cnt_d = bump(cnt_d);
              case (text_byte_i)
                ChB:     push = append(push, ChBs, KindData, cnt_d);
                ChF:     push = append(push, ChFf, KindData, cnt_d);
                ChN:     push = append(push, ChLf, KindData, cnt_d);
                ChR:     push = append(push, ChCr, KindData, cnt_d);
                ChS:     push = append(push, ChSpace, KindData, cnt_d);
                ChT:     push = append(push, ChTab, KindData, cnt_d);
                default: push = append(push, text_byte_i, KindData, cnt_d);
              endcase
            end
          endcase
        end
        PhOct: begin
          if (text_byte_i inside {[ChZero:ChSeven]}) begin
            acc_d  = {acc_q[4:0], text_byte_i[2:0]};
            digs_d = digs_q + 2'd1;
            if (digs_q == 2'd2) begin
              digs_d  = '0;
              phase_d = PhBody;
              cnt_d   = bump(cnt_d);
              push    = append(push, acc_d, KindData, cnt_d);
            end
          end else begin
            // Cut short: flush the value, then treat the byte as ordinary text
            digs_d  = '0;
            phase_d = PhBody;
            cnt_d   = bump(cnt_d);
            push    = append(push, acc_q, KindData, cnt_d);
            do_body = 1'b1;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end

    if (do_body) begin
      if (text_byte_i == ChNul) begin
        phase_d = PhIdle;
        push    = append(push, ChNul, qmode_d ? KindError : KindOk, cnt_d);
      end else if (qmode_d && text_byte_i == qbyte_d) begin
        phase_d = PhIdle;
        push    = append(push, ChNul, KindOk, cnt_d);
      end else if (!qmode_d && (text_byte_i == ChSpace || text_byte_i == ChTab ||
                                text_byte_i == ChCr || text_byte_i == ChLf)) begin
        phase_d = PhIdle;
        push    = append(push, ChNul, KindOk, cnt_d);
      end else if (text_byte_i == esc_q) begin
        phase_d = PhEsc;
      end else begin
        cnt_d = bump(cnt_d);
        push  = append(push, text_byte_i, KindData, cnt_d);
      end
    end

    // Mark the final result of this byte
    if (push.num == 2'd1) begin
      push.r0.last = 1'b1;
    end else if (push.num == 2'd2) begin
      push.r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      qmode_q <= 1'b0;
      qbyte_q <= '0;
      acc_q   <= '0;
      digs_q  <= '0;
      cnt_q   <= '0;
      esc_q   <= EscReset;
    end else begin
      if (cfg_we_i) begin
        esc_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q <= phase_d;
        qmode_q <= qmode_d;
        qbyte_q <= qbyte_d;
        acc_q   <= acc_d;
        digs_q  <= digs_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_comb begin
    push_o     = push;
    push_o.num = accept_i ? push.num : 2'd0;
  end

`ifndef NO_ASSERTIONS
  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.num != 2'd0 && ((push_o.num == 2'd1 && push_o.r0.kind != KindData) ||
     (push_o.num == 2'd2 && push_o.r1.kind != KindData))) |=> phase_q == PhIdle)
    else $error("end result did not return the scanner to idle");
  a_pair_starts_with_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.num == 2'd2 |-> push_o.r0.kind == KindData && !push_o.r0.last)
    else $error("first of two results must be a data byte");
  a_octal_digits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digs_q != 2'd3)
    else $error("octal digit counter overran");
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle && !starts_string_i) |-> push_o.num == 2'd0)
    else $error("result produced while idle");
`endif

endmodule
`default_nettype wire

[sv/ess_outq.sv]
// Small result queue: takes up to two results per cycle, hands out one per cycle while ready_i is high.
`default_nettype none
module ess_outq #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ess_pkg::push_t push_i,
  output      logic           room_o,
  output      logic           valid_o,
  input  wire logic           ready_i,
  output      ess_pkg::res_t  res_o
);
  import ess_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(DEPTH - 2);

  res_t            mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= RoomMax);
  assign res_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wptr_q + 1'b1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PtrW'(push_i.num);
      rptr_q  <= rptr_q + PtrW'(pop);
      count_q <= count_q + CntW'(push_i.num) - CntW'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room_o)
    else $error("results pushed without room");
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");
  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num == 2'd0 && !pop) |=> $stable(count_q))
    else $error("queue count moved with no push or pop");
`endif

endmodule
`default_nettype wire

[sv/escaped_string_scanner.sv]
// Top level of the escaped string scanner: stream ports, scanner core and result queue.
`default_nettype none
// The scanner reads one source byte per request on the slave stream and emits the
// unescaped string on the master stream. A request with tuser[0] set opens a new string,
// abandoning any open one; with tuser[1] also set, that byte is the quote character and
// the string runs to the next matching byte, otherwise it runs to a space, tab, CR or LF.
// The byte in the escape register (reset backslash; the user must write it through
// cfg_we_i/cfg_wdata_i only while the block is idle, which the block does not enforce)
// introduces an escape: b f n r s t become control characters or space, escape-zero takes
// up to three more octal digits, anything else passes as is. A NUL ends the string:
// successfully in plain mode, with an error in quoted mode or right after an escape. Each
// data result carries the running count of copied bytes (saturating at 65535); the end
// result (tuser 1 ok, 2 error) carries the final count and tlast marks the final result
// caused by each request. Bytes outside a string are dropped. Timing: every byte is
// decoded in the cycle it is accepted, so the slave side takes one byte per clock while
// tready is high. Results leave one per clock while the sink is ready, through a
// QUEUE_DEPTH entry queue (power of two, 2 to 32); a byte that cuts an octal escape short
// can yield two results. tready drops when fewer than two queue slots are free; with the
// default depth and an always-ready sink, plain text streams at one byte per clock.
module escaped_string_scanner #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // escape register write
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // source bytes
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic [1:0]  s_axis_tuser,   // [0] starts_string, [1] quoted
  // results
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] copied_total
  output      logic [1:0]  m_axis_tuser,   // [1:0] kind
  output      logic        m_axis_tlast    // last result of the request
);
  import ess_pkg::*;

  logic  accept;
  logic  room;
  push_t push;
  res_t  res;

  // Take a byte only while the queue can absorb the worst case of two results
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ess_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accept_i        (accept),
    .text_byte_i     (s_axis_tdata),
    .starts_string_i (s_axis_tuser[0]),
    .quoted_i        (s_axis_tuser[1]),
    .push_o          (push)
  );

  ess_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  // Pack the head result onto the master stream
  assign m_axis_tdata = {res.copied_total, res.out_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

[verif/scan_check_pkg.sv]
// Unescape predictor and result scoreboard for the escaped string scanner test.
package scan_check_pkg;
  import ess_pkg::*;

  typedef enum logic [1:0] {
    ScanIdle,
    ScanBody,
    ScanEscape,
    ScanOctal
  } scan_state_e;

  class unescape_board;
    logic [ByteW-1:0]  esc_ch;
    scan_state_e       state;
    bit                quote_mode;
    logic [ByteW-1:0]  quote_ch;
    logic [ByteW-1:0]  oct_val;
    int unsigned       oct_digits;
    logic [CountW-1:0] copied;
    res_t              step_out[$];
    res_t              predicted_out[$];
    int unsigned       fails;

    function new();
      esc_ch     = EscReset;
      state      = ScanIdle;
      quote_mode = 1'b0;
      quote_ch   = '0;
      oct_val    = '0;
      oct_digits = 0;
      copied     = '0;
      fails      = 0;
    endfunction

    function void set_escape(input logic [ByteW-1:0] value);
      esc_ch = value;
    endfunction

    function int unsigned pending();
      return predicted_out.size();
    endfunction

    function int unsigned failures();
      return fails;
    endfunction

    function void report(input string msg);
      fails++;
      if (fails <= 10) $display("%s", msg);
    endfunction

    function void emit(input logic [ByteW-1:0] b, input logic [KindW-1:0] k);
      res_t r;
      r.copied_total = copied;
      r.out_byte     = b;
      r.kind         = k;
      r.last         = 1'b0;
      step_out.push_back(r);
    endfunction

    function void put_data(input logic [ByteW-1:0] b);
      if (copied != CountMax) copied++;
      emit(b, KindData);
    endfunction

    // Terminator tests come before the escape test.
    function void take_body(input logic [ByteW-1:0] c);
      if (c == ChNul) begin
        state = ScanIdle;
        emit(ChNul, quote_mode ? KindError : KindOk);
      end else if (quote_mode && c == quote_ch) begin
        state = ScanIdle;
        emit(ChNul, KindOk);
      end else if (!quote_mode && (c == ChSpace || c == ChTab || c == ChCr || c == ChLf)) begin
        state = ScanIdle;
        emit(ChNul, KindOk);
      end else if (c == esc_ch) begin
        state = ScanEscape;
      end else begin
        put_data(c);
      end
    endfunction

    function void take_escape(input logic [ByteW-1:0] c);
      state = ScanBody;
      case (c)
        ChNul: begin
          state = ScanIdle;
          emit(ChNul, KindError);
        end
        ChB: put_data(ChBs);
        ChF: put_data(ChFf);
        ChN: put_data(ChLf);
        ChR: put_data(ChCr);
        ChS: put_data(ChSpace);
        ChT: put_data(ChTab);
        ChZero: begin
          state      = ScanOctal;
          oct_val    = '0;
          oct_digits = 0;
        end
        default: put_data(c);
      endcase
    endfunction

    // A non-octal byte flushes the partial value, then counts as a body byte.
    function void take_octal(input logic [ByteW-1:0] c);
      if (c >= ChZero && c <= ChSeven) begin
        oct_val = {oct_val[4:0], 3'b000} + (c - ChZero);
        oct_digits++;
        if (oct_digits >= 3) begin
          oct_digits = 0;
          state      = ScanBody;
          put_data(oct_val);
        end
      end else begin
        oct_digits = 0;
        state      = ScanBody;
        put_data(oct_val);
        take_body(c);
      end
    endfunction

    function void note_request(input logic [ByteW-1:0] c, input bit start, input bit quoted);
      step_out.delete();
      if (start) begin
        copied     = '0;
        oct_val    = '0;
        oct_digits = 0;
        quote_ch   = '0;
        quote_mode = quoted;
        if (quoted) begin
          if (c == ChNul) begin
            state = ScanIdle;
            emit(ChNul, KindError);
          end else begin
            quote_ch = c;
            state    = ScanBody;
          end
        end else begin
          state = ScanBody;
          take_body(c);
        end
      end else begin
        case (state)
          ScanBody:   take_body(c);
          ScanEscape: take_escape(c);
          ScanOctal:  take_octal(c);
          default:    state = ScanIdle;
        endcase
      end
      foreach (step_out[i]) begin
        res_t r;
        r      = step_out[i];
        r.last = (i == step_out.size() - 1);
        predicted_out.push_back(r);
      end
    endfunction

    function void check_result(input logic [23:0] tdata, input logic [1:0] tuser,
                               input logic tlast);
      res_t got;
      res_t want;
      got.out_byte     = tdata[7:0];
      got.copied_total = tdata[23:8];
      got.kind         = tuser;
      got.last         = tlast;
      if (predicted_out.size() == 0) begin
        report($sformatf("unexpected result: byte %h kind %0d count %0d last %0b",
                         got.out_byte, got.kind, got.copied_total, got.last));
        return;
      end
      want = predicted_out.pop_front();
      if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
          got.copied_total !== want.copied_total || got.last !== want.last)
        report($sformatf({"mismatch: expected byte %h kind %0d count %0d last %0b,",
                          " got byte %h kind %0d count %0d last %0b"},
                         want.out_byte, want.kind, want.copied_total, want.last,
                         got.out_byte, got.kind, got.copied_total, got.last));
    endfunction

    function void close_out();
      if (predicted_out.size() != 0)
        report($sformatf("%0d expected results never arrived", predicted_out.size()));
    endfunction
  endclass

endpackage

[verif/escaped_string_scanner_test.sv]
// Stream-level test of the escaped string scanner against its unescape predictor.
module escaped_string_scanner_test;
  import ess_pkg::*;
  import scan_check_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  unescape_board board = new();

  // Traffic shaping: percent of cycles the source holds off / the sink stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned requests_sent  = 0;
  logic [7:0]  esc_now        = EscReset;

  escaped_string_scanner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sink: stall at random according to the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check every result that completes a handshake at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Present one request and hold it until accepted. Returns right after the
  // accepting edge with tvalid still high, so a following request can keep it up.
  task automatic send_byte(input logic [7:0] b, input bit start, input bit quoted);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {quoted, start};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(b, start, quoted);
    requests_sent++;
  endtask

  // Drop tvalid and hold until every predicted result has come back (or a timeout
  // expires), then let the pipeline settle.
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() > 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Write the escape register only once the block has drained.
  task automatic write_escape(input logic [7:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_escape(value);
    esc_now = value;
  endtask

  function automatic logic [7:0] pick_text();
    if ($urandom_range(99) < 75) return 8'($urandom_range(8'h21, 8'h7e));
    return 8'($urandom_range(255));
  endfunction

  // One chunk of string content: plain text, a named escape, an octal escape
  // with 0..3 digits (so the next chunk may cut it short), or a raw escape.
  task automatic send_chunk();
    int unsigned pick;
    int unsigned digits;
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_byte(pick_text(), 1'b0, 1'b0);
    end else if (pick < 75) begin
      send_byte(esc_now, 1'b0, 1'b0);
      case ($urandom_range(6))
        0: send_byte(ChB, 1'b0, 1'b0);
        1: send_byte(ChF, 1'b0, 1'b0);
        2: send_byte(ChN, 1'b0, 1'b0);
        3: send_byte(ChR, 1'b0, 1'b0);
        4: send_byte(ChS, 1'b0, 1'b0);
        5: send_byte(ChT, 1'b0, 1'b0);
        default: send_byte(pick_text(), 1'b0, 1'b0);
      endcase
    end else if (pick < 92) begin
      send_byte(esc_now, 1'b0, 1'b0);
      send_byte(ChZero, 1'b0, 1'b0);
      digits = $urandom_range(3);
      repeat (digits) send_byte(8'($urandom_range(ChZero, ChSeven)), 1'b0, 1'b0);
    end else begin
      send_byte(esc_now, 1'b0, 1'b0);
      send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  // A whole string: opening request, random content, then a proper end, a
  // bad end, or nothing (the next opening abandons it). Stray bytes after.
  task automatic send_string();
    bit          quoted;
    logic [7:0]  quote;
    int unsigned chunks;
    int unsigned strays;
    int unsigned pick;
    logic [7:0]  blanks [4];
    blanks = '{ChSpace, ChTab, ChCr, ChLf};
    quoted = 1'($urandom_range(1));
    if (quoted) begin
      pick = $urandom_range(9);
      if (pick < 4)      quote = 8'h22;
      else if (pick < 6) quote = 8'h27;
      else if (pick < 7) quote = esc_now;
      else if (pick < 9) quote = 8'($urandom_range(1, 255));
      else               quote = ChNul;
      send_byte(quote, 1'b1, 1'b1);
    end else begin
      quote = ChNul;
      send_byte(pick_text(), 1'b1, 1'b0);
    end
    chunks = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    repeat (chunks) send_chunk();
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_byte(quoted ? quote : blanks[2'($urandom_range(3))], 1'b0, 1'b0);
    end else if (pick < 80) begin
      send_byte(ChNul, 1'b0, 1'b0);
    end else if (pick < 88) begin
      send_byte(esc_now, 1'b0, 1'b0);
      send_byte(ChNul, 1'b0, 1'b0);
    end
    strays = $urandom_range(2);
    repeat (strays) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    // stray bytes are mostly dropped by the block; leave them out of the tally
    requests_sent -= strays;
  endtask

  initial begin
    logic [7:0]  letters  [6];
    logic [7:0]  esc_vals [6];
    int unsigned send_pcts [4];
    int unsigned sink_pcts [4];
    int unsigned goal;
    letters   = '{ChB, ChF, ChN, ChR, ChS, ChT};
    send_pcts = '{0, 47, 0, 38};
    sink_pcts = '{0, 0, 47, 38};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte outside any string is dropped.
    send_byte(8'h78, 1'b0, 1'b0);
    // Plain string with every named escape, a full octal escape (\0101 -> 'A')
    // and an octal escape cut short by a blank (data then end in one request).
    send_byte(8'h61, 1'b1, 1'b0);
    foreach (letters[i]) begin
      send_byte(EscReset, 1'b0, 1'b0);
      send_byte(letters[i], 1'b0, 1'b0);
    end
    send_byte(EscReset, 1'b0, 1'b0);
    send_byte(ChZero, 1'b0, 1'b0);
    send_byte(8'h31, 1'b0, 1'b0);
    send_byte(ChZero, 1'b0, 1'b0);
    send_byte(8'h31, 1'b0, 1'b0);
    send_byte(EscReset, 1'b0, 1'b0);
    send_byte(ChZero, 1'b0, 1'b0);
    send_byte(ChSeven, 1'b0, 1'b0);
    send_byte(ChSpace, 1'b0, 1'b0);
    // Quoted start on NUL fails at once.
    send_byte(ChNul, 1'b1, 1'b1);
    // Quoted string with an all-ones byte, then NUL right after an escape.
    send_byte(8'h22, 1'b1, 1'b1);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(EscReset, 1'b0, 1'b0);
    send_byte(ChNul, 1'b0, 1'b0);
    // Quoted string abandoned by a new plain string, which a NUL ends cleanly.
    send_byte(8'h27, 1'b1, 1'b1);
    send_byte(8'h6b, 1'b0, 1'b0);
    send_byte(ChB, 1'b1, 1'b0);
    send_byte(ChNul, 1'b0, 1'b0);

    // Random strings over several escape settings and traffic patterns. Each
    // escape write sits behind a full drain, so the source pauses there.
    esc_vals = '{EscReset, 8'h00, 8'hff, 8'h22, ChSpace, 8'($urandom_range(255))};
    requests_sent = 0;
    foreach (esc_vals[p]) begin
      write_escape(esc_vals[p]);
      send_idle_pct  = send_pcts[p % 4];
      sink_stall_pct = sink_pcts[p % 4];
      goal = (p + 1) * 2000 / 6;
      while (requests_sent < goal) send_string();
    end

    wait_idle();
    board.close_out();
    if (board.failures() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
